### rtl/usbt_pkg.sv
// Shared types, codes and widths for the UDP socket binding table.
package usbt_pkg;

    localparam int OPCODE_W    = 3;
    localparam int ENTRY_W     = 4;
    localparam int ADDR_W      = 32;
    localparam int PORT_W      = 16;
    localparam int STATUS_W    = 3;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_WAITER_MAX = 255;

    localparam logic [PORT_W-1:0] EPH_LOW_RESET  = 16'd49152;
    localparam logic [PORT_W-1:0] EPH_HIGH_RESET = 16'd65535;

    localparam logic [CFG_INDEX_W-1:0] CFG_EPH_LOW  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EPH_HIGH = 1'b1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_OPEN       = 3'd0,
        OP_CLOSE      = 3'd1,
        OP_BIND       = 3'd2,
        OP_LOOKUP     = 3'd3,
        OP_ASSIGN     = 3'd4,
        OP_WAIT_BEGIN = 3'd5,
        OP_WAIT_END   = 3'd6
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        RC_OK       = 3'd0,
        RC_NOT_OPEN = 3'd1,
        RC_FULL     = 3'd2,
        RC_IN_USE   = 3'd3,
        RC_NO_PORT  = 3'd4,
        RC_CLOSED   = 3'd5
    } rc_t;

    typedef enum logic [1:0] {
        ENT_FREE    = 2'd0,
        ENT_OPEN    = 2'd1,
        ENT_CLOSING = 2'd2
    } ent_state_t;

    typedef enum logic [2:0] {
        WD_ZERO,
        WD_BIND,
        WD_PORT,
        WD_WAIT_INC,
        WD_WAIT_DEC
    } wdata_sel_t;

    typedef enum logic [1:0] {
        RP_ZERO,
        RP_CAND,
        RP_ENTRY
    } rport_sel_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_DECODE,
        CS_FREE_SCAN,
        CS_ENTRY,
        CS_EXEC,
        CS_MATCH_RD,
        CS_MATCH_CMP,
        CS_RESULT
    } ctl_state_t;

    typedef struct packed {
        logic       load_req;
        logic       ptr_clear;
        logic       ptr_inc;
        logic       rd_ptr;
        logic       ent_capture;
        logic       key_from_req;
        logic       key_from_assign;
        logic       cand_inc;
        logic       wr_ptr;
        logic       st_we;
        ent_state_t st_value;
        logic       mem_we;
        wdata_sel_t wdata_sel;
        logic       res_load;
        rc_t        res_code;
        logic       res_entry_ptr;
        logic       res_addr_chosen;
        rport_sel_t res_port_sel;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        op_t        opcode;
        logic       idx_valid;
        ent_state_t idx_state;
        logic       free_here;
        logic       ptr_last;
        logic       hit;
        logic       ent_waiters_zero;
        logic       ent_port_zero;
        logic       wait_dec_zero;
        logic       range_empty;
        logic       cand_at_high;
        logic       cand_zero;
        logic       out_free;
    } dp_stat_t;

endpackage

### rtl/usbt_datapath.sv
// Datapath: entry state bits, entry memory, scan pointer, config and result registers.
module usbt_datapath #(
    parameter int ENTRIES    = usbt_pkg::DEF_ENTRIES,
    parameter int WAITER_MAX = usbt_pkg::DEF_WAITER_MAX
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [usbt_pkg::OPCODE_W-1:0]    opcode,
    input  logic [usbt_pkg::ENTRY_W-1:0]     request_entry,
    input  logic [usbt_pkg::ADDR_W-1:0]      request_addr,
    input  logic [usbt_pkg::PORT_W-1:0]      request_port,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [usbt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [usbt_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic [usbt_pkg::STATUS_W-1:0]    status,
    output logic [usbt_pkg::ENTRY_W-1:0]     result_entry,
    output logic [usbt_pkg::ADDR_W-1:0]      result_addr,
    output logic [usbt_pkg::PORT_W-1:0]      result_port,
    input  usbt_pkg::dp_cmd_t                cmd,
    output usbt_pkg::dp_stat_t               dp_stat
);
    import usbt_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int WAIT_W = $clog2(WAITER_MAX + 1);
    localparam int MEM_W  = ADDR_W + PORT_W + WAIT_W;

    logic [OPCODE_W-1:0] req_opcode_reg;
    logic [ENTRY_W-1:0]  req_entry_reg;
    logic [ADDR_W-1:0]   req_addr_reg;
    logic [PORT_W-1:0]   req_port_reg;

    logic [PORT_W-1:0]   eph_low_reg;
    logic [PORT_W-1:0]   eph_high_reg;

    ent_state_t          entry_state_reg [ENTRIES];
    logic [MEM_W-1:0]    mem [ENTRIES];
    logic [MEM_W-1:0]    rd_data_reg;
    logic [IDX_W-1:0]    ptr_reg;

    logic [ADDR_W-1:0]   ent_addr_reg;
    logic [PORT_W-1:0]   ent_port_reg;
    logic [WAIT_W-1:0]   ent_waiters_reg;

    logic [ADDR_W-1:0]   key_addr_reg;
    logic [PORT_W-1:0]   key_port_reg;

    rc_t                 res_status_reg;
    logic [ENTRY_W-1:0]  res_entry_reg;
    logic [ADDR_W-1:0]   res_addr_reg;
    logic [PORT_W-1:0]   res_port_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [ENTRY_W-1:0]  out_entry_reg;
    logic [ADDR_W-1:0]   out_addr_reg;
    logic [PORT_W-1:0]   out_port_reg;

    logic [IDX_W-1:0]    idx;
    logic [IDX_W-1:0]    rd_idx;
    logic [IDX_W-1:0]    wr_idx;
    logic [ADDR_W-1:0]   rd_addr;
    logic [PORT_W-1:0]   rd_port;
    logic [ADDR_W-1:0]   chosen_addr;
    logic [WAIT_W-1:0]   waiters_inc;
    logic [WAIT_W-1:0]   waiters_dec;
    logic [MEM_W-1:0]    mem_wdata;

    assign idx     = IDX_W'(req_entry_reg);
    assign rd_idx  = cmd.rd_ptr ? ptr_reg : idx;
    assign wr_idx  = cmd.wr_ptr ? ptr_reg : idx;
    assign rd_addr = rd_data_reg[MEM_W-1 -: ADDR_W];
    assign rd_port = rd_data_reg[WAIT_W+PORT_W-1 -: PORT_W];

    assign chosen_addr = (ent_addr_reg != '0) ? ent_addr_reg : req_addr_reg;
    assign waiters_inc = (ent_waiters_reg < WAIT_W'(WAITER_MAX)) ?
                         ent_waiters_reg + WAIT_W'(1) : ent_waiters_reg;
    assign waiters_dec = (ent_waiters_reg != '0) ?
                         ent_waiters_reg - WAIT_W'(1) : ent_waiters_reg;

    always_comb
    begin
        case (cmd.wdata_sel)
            WD_ZERO:     mem_wdata = '0;
            WD_BIND:     mem_wdata = {req_addr_reg, req_port_reg, ent_waiters_reg};
            WD_PORT:     mem_wdata = {ent_addr_reg, key_port_reg, ent_waiters_reg};
            WD_WAIT_INC: mem_wdata = {ent_addr_reg, ent_port_reg, waiters_inc};
            WD_WAIT_DEC: mem_wdata = {ent_addr_reg, ent_port_reg, waiters_dec};
            default:     mem_wdata = '0;
        endcase
    end

    // Request word
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_opcode_reg <= opcode;
            req_entry_reg  <= request_entry;
            req_addr_reg   <= request_addr;
            req_port_reg   <= request_port;
        end
    end

    // Ephemeral port range
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eph_low_reg  <= EPH_LOW_RESET;
            eph_high_reg <= EPH_HIGH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_EPH_LOW:  eph_low_reg  <= cfg_data;
                CFG_EPH_HIGH: eph_high_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Entry state, cleared to free by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                entry_state_reg[i] <= ENT_FREE;
            end
        end
        else if (cmd.st_we)
        begin
            entry_state_reg[wr_idx] <= cmd.st_value;
        end
    end

    // Entry memory: {addr, port, waiters}; an entry is rewritten to zero when opened
    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
        begin
            mem[wr_idx] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else if (cmd.ptr_clear)
        begin
            ptr_reg <= '0;
        end
        else if (cmd.ptr_inc)
        begin
            ptr_reg <= ptr_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ent_capture)
        begin
            ent_addr_reg    <= rd_addr;
            ent_port_reg    <= rd_port;
            ent_waiters_reg <= rd_data_reg[WAIT_W-1:0];
        end
    end

    // Match key; key_port_reg is also the candidate port of an assign
    always_ff @(posedge clk)
    begin
        if (cmd.key_from_req)
        begin
            key_addr_reg <= req_addr_reg;
            key_port_reg <= req_port_reg;
        end
        else if (cmd.key_from_assign)
        begin
            key_addr_reg <= chosen_addr;
            key_port_reg <= eph_low_reg;
        end
        else if (cmd.cand_inc)
        begin
            key_port_reg <= key_port_reg + PORT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_code;
            res_entry_reg  <= cmd.res_entry_ptr ? ENTRY_W'(ptr_reg) : '0;
            res_addr_reg   <= cmd.res_addr_chosen ? chosen_addr : '0;
            case (cmd.res_port_sel)
                RP_CAND:  res_port_reg <= key_port_reg;
                RP_ENTRY: res_port_reg <= ent_port_reg;
                default:  res_port_reg <= '0;
            endcase
        end
    end

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_entry_reg  <= res_entry_reg;
            out_addr_reg   <= res_addr_reg;
            out_port_reg   <= res_port_reg;
        end
    end

    assign rsp_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign result_entry = out_entry_reg;
    assign result_addr  = out_addr_reg;
    assign result_port  = out_port_reg;

    always_comb
    begin
        dp_stat.opcode           = op_t'(req_opcode_reg);
        dp_stat.idx_valid        = int'(req_entry_reg) < ENTRIES;
        dp_stat.idx_state        = entry_state_reg[idx];
        dp_stat.free_here        = entry_state_reg[ptr_reg] == ENT_FREE;
        dp_stat.ptr_last         = ptr_reg == IDX_W'(ENTRIES - 1);
        dp_stat.hit              = (entry_state_reg[ptr_reg] == ENT_OPEN) &&
                                   ((rd_addr == '0) || (rd_addr == key_addr_reg)) &&
                                   (rd_port == key_port_reg);
        dp_stat.ent_waiters_zero = ent_waiters_reg == '0;
        dp_stat.ent_port_zero    = ent_port_reg == '0;
        dp_stat.wait_dec_zero    = waiters_dec == '0;
        dp_stat.range_empty      = eph_low_reg > eph_high_reg;
        dp_stat.cand_at_high     = key_port_reg == eph_high_reg;
        dp_stat.cand_zero        = key_port_reg == '0;
        dp_stat.out_free         = !out_valid_reg || !rsp_stall;
    end

`ifndef SYNTH
    a_open_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.st_we && cmd.st_value == ENT_OPEN |-> entry_state_reg[wr_idx] == ENT_FREE)
        else $error("entry opened while not free");

    a_free_clears_binding: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.st_we && cmd.st_value == ENT_FREE |-> cmd.mem_we && cmd.wdata_sel == WD_ZERO)
        else $error("entry freed without clearing its binding");

    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_valid_reg || !rsp_stall)
        else $error("pending response word overwritten");

    a_cand_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cand_inc |-> key_port_reg != eph_high_reg)
        else $error("candidate port stepped past range end");
`endif

endmodule

### rtl/usbt_ctrl.sv
// Controller state machine sequencing table operations.
module usbt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  usbt_pkg::dp_stat_t dp_stat,
    output usbt_pkg::dp_cmd_t  cmd
);
    import usbt_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = state_reg != CS_IDLE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = CS_DECODE;
                end
            end

            CS_DECODE:
            begin
                case (dp_stat.opcode)
                    OP_OPEN:
                    begin
                        cmd.ptr_clear = 1'b1;
                        state_next    = CS_FREE_SCAN;
                    end
                    OP_LOOKUP:
                    begin
                        cmd.ptr_clear    = 1'b1;
                        cmd.key_from_req = 1'b1;
                        state_next       = CS_MATCH_RD;
                    end
                    OP_CLOSE, OP_BIND, OP_ASSIGN, OP_WAIT_BEGIN:
                    begin
                        if (dp_stat.idx_valid && dp_stat.idx_state == ENT_OPEN)
                        begin
                            state_next = CS_ENTRY;
                        end
                        else
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_code = RC_NOT_OPEN;
                            state_next   = CS_RESULT;
                        end
                    end
                    OP_WAIT_END:
                    begin
                        if (dp_stat.idx_valid && dp_stat.idx_state != ENT_FREE)
                        begin
                            state_next = CS_ENTRY;
                        end
                        else
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_code = RC_NOT_OPEN;
                            state_next   = CS_RESULT;
                        end
                    end
                    default:
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_code = RC_NOT_OPEN;
                        state_next   = CS_RESULT;
                    end
                endcase
            end

            CS_FREE_SCAN:
            begin
                if (dp_stat.free_here)
                begin
                    cmd.wr_ptr        = 1'b1;
                    cmd.st_we         = 1'b1;
                    cmd.st_value      = ENT_OPEN;
                    cmd.mem_we        = 1'b1;
                    cmd.wdata_sel     = WD_ZERO;
                    cmd.res_load      = 1'b1;
                    cmd.res_code      = RC_OK;
                    cmd.res_entry_ptr = 1'b1;
                    state_next        = CS_RESULT;
                end
                else if (dp_stat.ptr_last)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = RC_FULL;
                    state_next   = CS_RESULT;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                end
            end

            CS_ENTRY:
            begin
                cmd.ent_capture = 1'b1;
                state_next      = CS_EXEC;
            end

            CS_EXEC:
            begin
                case (dp_stat.opcode)
                    OP_CLOSE:
                    begin
                        cmd.st_we = 1'b1;
                        if (dp_stat.ent_waiters_zero)
                        begin
                            cmd.st_value  = ENT_FREE;
                            cmd.mem_we    = 1'b1;
                            cmd.wdata_sel = WD_ZERO;
                        end
                        else
                        begin
                            cmd.st_value = ENT_CLOSING;
                        end
                        cmd.res_load = 1'b1;
                        cmd.res_code = RC_OK;
                        state_next   = CS_RESULT;
                    end
                    OP_BIND:
                    begin
                        cmd.ptr_clear    = 1'b1;
                        cmd.key_from_req = 1'b1;
                        state_next       = CS_MATCH_RD;
                    end
                    OP_ASSIGN:
                    begin
                        if (!dp_stat.ent_port_zero)
                        begin
                            cmd.res_load        = 1'b1;
                            cmd.res_code        = RC_OK;
                            cmd.res_addr_chosen = 1'b1;
                            cmd.res_port_sel    = RP_ENTRY;
                            state_next          = CS_RESULT;
                        end
                        else if (dp_stat.range_empty)
                        begin
                            cmd.res_load        = 1'b1;
                            cmd.res_code        = RC_NO_PORT;
                            cmd.res_addr_chosen = 1'b1;
                            state_next          = CS_RESULT;
                        end
                        else
                        begin
                            cmd.ptr_clear       = 1'b1;
                            cmd.key_from_assign = 1'b1;
                            state_next          = CS_MATCH_RD;
                        end
                    end
                    OP_WAIT_BEGIN:
                    begin
                        cmd.mem_we    = 1'b1;
                        cmd.wdata_sel = WD_WAIT_INC;
                        cmd.res_load  = 1'b1;
                        cmd.res_code  = RC_OK;
                        state_next    = CS_RESULT;
                    end
                    OP_WAIT_END:
                    begin
                        cmd.mem_we   = 1'b1;
                        cmd.res_load = 1'b1;
                        if (dp_stat.idx_state == ENT_CLOSING)
                        begin
                            cmd.res_code = RC_CLOSED;
                            if (dp_stat.wait_dec_zero)
                            begin
                                cmd.st_we     = 1'b1;
                                cmd.st_value  = ENT_FREE;
                                cmd.wdata_sel = WD_ZERO;
                            end
                            else
                            begin
                                cmd.wdata_sel = WD_WAIT_DEC;
                            end
                        end
                        else
                        begin
                            cmd.res_code  = RC_OK;
                            cmd.wdata_sel = WD_WAIT_DEC;
                        end
                        state_next = CS_RESULT;
                    end
                    default:
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_code = RC_NOT_OPEN;
                        state_next   = CS_RESULT;
                    end
                endcase
            end

            CS_MATCH_RD:
            begin
                cmd.rd_ptr = 1'b1;
                state_next = CS_MATCH_CMP;
            end

            CS_MATCH_CMP:
            begin
                if (dp_stat.hit)
                begin
                    case (dp_stat.opcode)
                        OP_LOOKUP:
                        begin
                            cmd.res_load      = 1'b1;
                            cmd.res_code      = RC_OK;
                            cmd.res_entry_ptr = 1'b1;
                            state_next        = CS_RESULT;
                        end
                        OP_BIND:
                        begin
                            cmd.res_load      = 1'b1;
                            cmd.res_code      = RC_IN_USE;
                            cmd.res_entry_ptr = 1'b1;
                            state_next        = CS_RESULT;
                        end
                        OP_ASSIGN:
                        begin
                            if (dp_stat.cand_at_high)
                            begin
                                cmd.res_load        = 1'b1;
                                cmd.res_code        = RC_NO_PORT;
                                cmd.res_addr_chosen = 1'b1;
                                state_next          = CS_RESULT;
                            end
                            else
                            begin
                                cmd.cand_inc  = 1'b1;
                                cmd.ptr_clear = 1'b1;
                                state_next    = CS_MATCH_RD;
                            end
                        end
                        default:
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_code = RC_NOT_OPEN;
                            state_next   = CS_RESULT;
                        end
                    endcase
                end
                else if (dp_stat.ptr_last)
                begin
                    case (dp_stat.opcode)
                        OP_BIND:
                        begin
                            cmd.mem_we    = 1'b1;
                            cmd.wdata_sel = WD_BIND;
                            cmd.res_load  = 1'b1;
                            cmd.res_code  = RC_OK;
                        end
                        OP_ASSIGN:
                        begin
                            cmd.mem_we          = 1'b1;
                            cmd.wdata_sel       = WD_PORT;
                            cmd.res_load        = 1'b1;
                            cmd.res_addr_chosen = 1'b1;
                            cmd.res_port_sel    = RP_CAND;
                            // a port of zero leaves the entry unbound
                            if (dp_stat.cand_zero)
                            begin
                                cmd.res_code = RC_NO_PORT;
                            end
                            else
                            begin
                                cmd.res_code = RC_OK;
                            end
                        end
                        default:
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_code = RC_NOT_OPEN;
                        end
                    endcase
                    state_next = CS_RESULT;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = CS_MATCH_RD;
                end
            end

            CS_RESULT:
            begin
                if (dp_stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = CS_IDLE;
                end
            end

            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

### rtl/udp_socket_binding_table_unit.sv
// UDP socket binding table: top level joining controller and datapath.
//
// One request word at a time. Entries live in a memory that the match scan
// walks one entry at a time, reading each entry and then comparing it; lookup
// and bind examine up to ENTRIES entries. Open walks the free/open state bits
// at one entry per cycle; close and the wait operations capture the entry and
// then update it; assign with no port yet repeats the match scan for every
// ephemeral port it tries. The unit returns to idle before it takes the next
// request. Results sit in an output register, so a pending response does not
// hold up the next request.
module udp_socket_binding_table_unit #(
    parameter int ENTRIES    = usbt_pkg::DEF_ENTRIES,
    parameter int WAITER_MAX = usbt_pkg::DEF_WAITER_MAX
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic [usbt_pkg::OPCODE_W-1:0]    opcode,
    input  logic [usbt_pkg::ENTRY_W-1:0]     request_entry,
    input  logic [usbt_pkg::ADDR_W-1:0]      request_addr,
    input  logic [usbt_pkg::PORT_W-1:0]      request_port,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic [usbt_pkg::STATUS_W-1:0]    status,
    output logic [usbt_pkg::ENTRY_W-1:0]     result_entry,
    output logic [usbt_pkg::ADDR_W-1:0]      result_addr,
    output logic [usbt_pkg::PORT_W-1:0]      result_port,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [usbt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [usbt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import usbt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t dp_stat;

    usbt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .dp_stat   (dp_stat),
        .cmd       (cmd)
    );

    usbt_datapath #(
        .ENTRIES    (ENTRIES),
        .WAITER_MAX (WAITER_MAX)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .opcode        (opcode),
        .request_entry (request_entry),
        .request_addr  (request_addr),
        .request_port  (request_port),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .result_entry  (result_entry),
        .result_addr   (result_addr),
        .result_port   (result_port),
        .cmd           (cmd),
        .dp_stat       (dp_stat)
    );

endmodule

### sim/socket_table_checker.sv
// Checker: mirrors the socket table, predicts each reply word and compares it.
module socket_table_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    input  logic                             req_stall,
    input  logic [usbt_pkg::OPCODE_W-1:0]    opcode,
    input  logic [usbt_pkg::ENTRY_W-1:0]     request_entry,
    input  logic [usbt_pkg::ADDR_W-1:0]      request_addr,
    input  logic [usbt_pkg::PORT_W-1:0]      request_port,
    input  logic                             rsp_valid,
    input  logic                             rsp_stall,
    input  logic [usbt_pkg::STATUS_W-1:0]    status,
    input  logic [usbt_pkg::ENTRY_W-1:0]     result_entry,
    input  logic [usbt_pkg::ADDR_W-1:0]      result_addr,
    input  logic [usbt_pkg::PORT_W-1:0]      result_port,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [usbt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [usbt_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               mismatches,
    output int                               replies_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import usbt_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ENTRY_W-1:0]  entry;
        logic [ADDR_W-1:0]   addr;
        logic [PORT_W-1:0]   port;
    } socket_reply_t;

    ent_state_t        sock_state   [DEF_ENTRIES];
    logic [ADDR_W-1:0] sock_addr    [DEF_ENTRIES];
    logic [PORT_W-1:0] sock_port    [DEF_ENTRIES];
    int unsigned       sock_waiters [DEF_ENTRIES];
    logic [PORT_W-1:0] eph_low;
    logic [PORT_W-1:0] eph_high;
    socket_reply_t     owed_q [$];
    int                k;

    task automatic report(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    function automatic int first_open_match(input logic [ADDR_W-1:0] a,
                                            input logic [PORT_W-1:0] p);
        int hit;
        int i;
        hit = -1;
        for (i = DEF_ENTRIES - 1; i >= 0; i--)
        begin
            if (sock_state[i] == ENT_OPEN && (sock_addr[i] == '0 || sock_addr[i] == a)
                && sock_port[i] == p)
            begin
                hit = i;
            end
        end
        return hit;
    endfunction

    task automatic release_socket(input int e);
        sock_state[e] = ENT_FREE;
        sock_addr[e]  = '0;
        sock_port[e]  = '0;
    endtask

    task automatic model_socket_op(input logic [OPCODE_W-1:0] op,
                                   input logic [ENTRY_W-1:0]  e,
                                   input logic [ADDR_W-1:0]   a,
                                   input logic [PORT_W-1:0]   p);
        socket_reply_t     r;
        int                m;
        int                i;
        int                cand;
        logic              is_open;
        logic              found;
        logic [ADDR_W-1:0] use_addr;
        r        = '0;
        r.status = RC_NOT_OPEN;
        is_open  = (sock_state[e] == ENT_OPEN);
        found    = 1'b0;
        case (op)
            OP_OPEN:
            begin
                r.status = RC_FULL;
                for (i = 0; i < DEF_ENTRIES; i++)
                begin
                    if (!found && sock_state[i] == ENT_FREE)
                    begin
                        sock_state[i] = ENT_OPEN;
                        r.status      = RC_OK;
                        r.entry       = i[ENTRY_W-1:0];
                        found         = 1'b1;
                    end
                end
            end
            OP_CLOSE:
            begin
                if (is_open)
                begin
                    if (sock_waiters[e] != 0)
                        sock_state[e] = ENT_CLOSING;
                    else
                        release_socket(e);
                    r.status = RC_OK;
                end
            end
            OP_BIND:
            begin
                if (is_open)
                begin
                    m = first_open_match(a, p);
                    if (m >= 0)
                    begin
                        r.status = RC_IN_USE;
                        r.entry  = m[ENTRY_W-1:0];
                    end
                    else
                    begin
                        sock_addr[e] = a;
                        sock_port[e] = p;
                        r.status     = RC_OK;
                    end
                end
            end
            OP_LOOKUP:
            begin
                m = first_open_match(a, p);
                if (m >= 0)
                begin
                    r.status = RC_OK;
                    r.entry  = m[ENTRY_W-1:0];
                end
            end
            OP_ASSIGN:
            begin
                if (is_open)
                begin
                    use_addr = (sock_addr[e] != '0) ? sock_addr[e] : a;
                    r.addr   = use_addr;
                    if (sock_port[e] == '0)
                    begin
                        for (cand = eph_low; cand <= eph_high && !found; cand++)
                        begin
                            if (first_open_match(use_addr, cand[PORT_W-1:0]) < 0)
                            begin
                                sock_port[e] = cand[PORT_W-1:0];
                                found        = 1'b1;
                            end
                        end
                    end
                    r.port   = sock_port[e];
                    r.status = (sock_port[e] != '0) ? RC_OK : RC_NO_PORT;
                end
            end
            OP_WAIT_BEGIN:
            begin
                if (is_open)
                begin
                    if (sock_waiters[e] < DEF_WAITER_MAX)
                        sock_waiters[e]++;
                    r.status = RC_OK;
                end
            end
            OP_WAIT_END:
            begin
                if (sock_state[e] != ENT_FREE)
                begin
                    if (sock_waiters[e] != 0)
                        sock_waiters[e]--;
                    if (sock_state[e] == ENT_CLOSING)
                    begin
                        if (sock_waiters[e] == 0)
                            release_socket(e);
                        r.status = RC_CLOSED;
                    end
                    else
                    begin
                        r.status = RC_OK;
                    end
                end
            end
            default:
            begin
            end
        endcase
        owed_q.push_back(r);
    endtask

    task automatic check_reply();
        socket_reply_t want;
        if (owed_q.size() == 0)
        begin
            report($sformatf("reply word with nothing outstanding: status %0d entry %0d",
                             status, result_entry));
        end
        else
        begin
            want = owed_q.pop_front();
            if (status !== want.status)
                report($sformatf("status: got %0d, want %0d", status, want.status));
            if (result_entry !== want.entry)
                report($sformatf("result_entry: got %0d, want %0d", result_entry, want.entry));
            if (result_addr !== want.addr)
                report($sformatf("result_addr: got %h, want %h", result_addr, want.addr));
            if (result_port !== want.port)
                report($sformatf("result_port: got %0d, want %0d", result_port, want.port));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (k = 0; k < DEF_ENTRIES; k++)
            begin
                release_socket(k);
                sock_waiters[k] = 0;
            end
            eph_low      = EPH_LOW_RESET;
            eph_high     = EPH_HIGH_RESET;
            owed_q.delete();
            mismatches   = 0;
            replies_owed = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
                check_reply();
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_EPH_LOW:  eph_low  = cfg_data;
                    CFG_EPH_HIGH: eph_high = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (req_valid && !req_stall)
                model_socket_op(opcode, request_entry, request_addr, request_port);
            replies_owed = owed_q.size();
        end
    end

endmodule

### sim/udp_socket_binding_table_unit_tb.sv
// Testbench top: drives requests, port-range settings and reply stalls, gives the verdict.
module udp_socket_binding_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import usbt_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED   = 3'd7;
    localparam int                  CYCLE_LIMIT = 3_000_000;
    localparam int                  PHASE_WORDS = 85;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   req_valid     = 1'b0;
    logic                   req_stall;
    logic [OPCODE_W-1:0]    opcode        = '0;
    logic [ENTRY_W-1:0]     request_entry = '0;
    logic [ADDR_W-1:0]      request_addr  = '0;
    logic [PORT_W-1:0]      request_port  = '0;
    logic                   rsp_valid;
    logic                   rsp_stall     = 1'b0;
    logic [STATUS_W-1:0]    status;
    logic [ENTRY_W-1:0]     result_entry;
    logic [ADDR_W-1:0]      result_addr;
    logic [PORT_W-1:0]      result_port;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    int                     mismatches;
    int                     replies_owed;

    logic                   calm          = 1'b0;
    int                     stall_left    = 0;
    int                     cycle_count   = 0;
    logic [PORT_W-1:0]      cur_low       = EPH_LOW_RESET;

    udp_socket_binding_table_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .opcode        (opcode),
        .request_entry (request_entry),
        .request_addr  (request_addr),
        .request_port  (request_port),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .result_entry  (result_entry),
        .result_addr   (result_addr),
        .result_port   (result_port),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    socket_table_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .opcode        (opcode),
        .request_entry (request_entry),
        .request_addr  (request_addr),
        .request_port  (request_port),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .result_entry  (result_entry),
        .result_addr   (result_addr),
        .result_port   (result_port),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .replies_owed  (replies_owed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("udp_socket_binding_table_unit_tb failed");
            $finish;
        end
    end

    // reply-side backpressure in bursts of random length
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 11) == 0)
        begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 15);
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    function automatic logic [ADDR_W-1:0] pick_addr();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return 32'h0A00_0001;
            4:       return 32'h0A00_0002;
            5:       return 32'hC0A8_0101;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [PORT_W-1:0] pick_port();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return 16'd53;
            3, 4:    return 16'd80;
            5:       return cur_low;
            6:       return cur_low + 16'd1;
            7:       return cur_low + 16'd2;
            default: return PORT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_req(input logic [OPCODE_W-1:0] op, input int e,
                            input logic [ADDR_W-1:0] a, input logic [PORT_W-1:0] p);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat ($urandom_range(0, 15)) @(negedge clk);
        end
        @(negedge clk);
        req_valid     <= 1'b1;
        opcode        <= op;
        request_entry <= e[ENTRY_W-1:0];
        request_addr  <= a;
        request_port  <= p;
        do @(posedge clk); while (req_stall);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // sender holds off until every reply word is back
    task automatic settle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (replies_owed != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic random_op(output int sent);
        int                  pick;
        int                  e;
        logic [ADDR_W-1:0]   a;
        logic [PORT_W-1:0]   p;
        logic [OPCODE_W-1:0] op;
        pick = $urandom_range(0, 99);
        e    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 7);
        a    = pick_addr();
        p    = pick_port();
        sent = 1;
        if (pick < 12)
        begin
            // socket life: bind, demux it back, pick a local port
            send_req(OP_BIND, e, a, p);
            send_req(OP_LOOKUP, 0, ($urandom_range(0, 3) == 0) ? pick_addr() : a, p);
            send_req(OP_ASSIGN, e, pick_addr(), pick_port());
            sent = 3;
        end
        else
        begin
            if (pick < 26)      op = OP_OPEN;
            else if (pick < 38) op = OP_CLOSE;
            else if (pick < 52) op = OP_BIND;
            else if (pick < 68) op = OP_LOOKUP;
            else if (pick < 80) op = OP_ASSIGN;
            else if (pick < 89) op = OP_WAIT_BEGIN;
            else if (pick < 98) op = OP_WAIT_END;
            else                op = OP_UNUSED;
            send_req(op, e, a, p);
        end
    endtask

    initial
    begin
        int                n;
        int                sent;
        int                ph;
        logic [PORT_W-1:0] lo;
        logic [PORT_W-1:0] hi;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        send_req(OP_LOOKUP, 0, '0, '0);
        send_req(OP_WAIT_END, 0, '0, '0);
        send_req(OP_UNUSED, 15, 32'hFFFF_FFFF, 16'hFFFF);
        repeat (17) send_req(OP_OPEN, 0, '0, '0);
        send_req(OP_BIND, 0, 32'h0A00_0001, 16'd80);
        send_req(OP_BIND, 1, 32'h0A00_0001, 16'd80);
        send_req(OP_BIND, 15, 32'hFFFF_FFFF, 16'hFFFF);
        send_req(OP_LOOKUP, 0, 32'h0A00_0001, 16'd80);
        send_req(OP_LOOKUP, 0, 32'hFFFF_FFFF, 16'hFFFF);
        send_req(OP_ASSIGN, 2, 32'h0A00_0002, '0);
        send_req(OP_ASSIGN, 15, '0, '0);
        send_req(OP_WAIT_BEGIN, 3, '0, '0);
        send_req(OP_CLOSE, 3, '0, '0);
        send_req(OP_WAIT_END, 3, '0, '0);

        // waiter count up to saturation, close while waiting, drain to free
        repeat (258) send_req(OP_WAIT_BEGIN, 5, pick_addr(), pick_port());
        send_req(OP_CLOSE, 5, '0, '0);
        repeat (256) send_req(OP_WAIT_END, 5, pick_addr(), pick_port());

        for (ph = 0; ph < 6; ph++)
        begin
            settle();
            case (ph)
                0:       begin lo = 16'd1;     hi = 16'd65535; end
                1:       begin lo = 16'd65535; hi = 16'd65535; end
                2:       begin lo = 16'd1;     hi = 16'd1;     end
                3:       begin lo = 16'd65535; hi = 16'd1;     end
                4:
                begin
                    lo = PORT_W'($urandom_range(1, 65531));
                    hi = lo + PORT_W'($urandom_range(0, 4));
                end
                default: begin lo = EPH_LOW_RESET; hi = EPH_HIGH_RESET; end
            endcase
            write_reg(CFG_EPH_LOW, lo);
            write_reg(CFG_EPH_HIGH, hi);
            cur_low = lo;
            n = 0;
            while (n < PHASE_WORDS)
            begin
                calm = (ph == 5) || (ph == 1 && n >= 40);
                random_op(sent);
                n += sent;
            end
        end

        settle();
        if (mismatches == 0 && replies_owed == 0)
            $display("udp_socket_binding_table_unit_tb passed");
        else
            $display("udp_socket_binding_table_unit_tb failed");
        $finish;
    end

endmodule
